// File: rtl/core/shadow_memory_access_checker_defines.svh
// assertion macros for the shadow memory access checker
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_DEFINES_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_DEFINES_SVH

// same-cycle implication, held off during reset
`define SMAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/smac_pkg.sv
// shared types and constants of the shadow memory access checker
`default_nettype none

package smac_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 20;
    localparam int TOP_W      = 32;
    localparam int SIZE_W     = 20;
    localparam int SIDX_W     = 16;
    localparam int FCNT_W     = 17;
    localparam int SHADOW_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // granule offset within the pool fits here for any 20-bit pool size
    localparam int GIDX_W     = 18;
    localparam int GRAN_SHIFT = 3;
    localparam int GRAN_OFF_W = 3;

    localparam logic [GRAN_OFF_W-1:0] GRAN_LAST_OFF = 3'h7;

    localparam logic [TOP_W-1:0]  POOL_TOP_RESET  = 32'h0EF0_0000;
    localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 20'h8_0000;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_FILL  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OUTSIDE   = 2'd1,
        STATUS_VIOLATION = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_TOP  = 1'b0,
        CFG_POOL_SIZE = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RANGE,
        ST_LOCATE,
        ST_MUL,
        ST_SCALE,
        ST_WRAP,
        ST_SCAN,
        ST_FILL_SETUP,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TOP_W-1:0]  pool_top;
        logic [SIZE_W-1:0] pool_size;
    } pool_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/smac_ram.sv
// generic single-write, single-read RAM with registered read data
`default_nettype none

module smac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/smac_cfg.sv
// pool configuration registers
`default_nettype none

module smac_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [smac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smac_pkg::CFG_DATA_W-1:0]    cfg_data,
    output smac_pkg::pool_cfg_t                     pool
);

    logic [smac_pkg::TOP_W-1:0]  top_reg;
    logic [smac_pkg::TOP_W-1:0]  top_next;
    logic [smac_pkg::SIZE_W-1:0] size_reg;
    logic [smac_pkg::SIZE_W-1:0] size_next;

    always_comb
    begin
        top_next  = top_reg;
        size_next = size_reg;
        if (cfg_valid)
        begin
            case (smac_pkg::cfg_reg_t'(cfg_index))
                smac_pkg::CFG_POOL_TOP:  top_next  = cfg_data[smac_pkg::TOP_W-1:0];
                smac_pkg::CFG_POOL_SIZE: size_next = cfg_data[smac_pkg::SIZE_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= smac_pkg::POOL_TOP_RESET;
            size_reg <= smac_pkg::POOL_SIZE_RESET;
        end
        else
        begin
            top_reg  <= top_next;
            size_reg <= size_next;
        end
    end

    // the user must write only while the block is idle; the block itself does not enforce it, so always ready
    assign cfg_ready      = 1'b1;
    assign pool.pool_top  = top_reg;
    assign pool.pool_size = size_reg;

endmodule

`default_nettype wire

// File: rtl/core/smac_engine.sv
// sequencer: store clear, range test, entry location, shadow scan and fill
`default_nettype none

module smac_engine #(
    parameter int SHADOW_ENTRIES = 65536
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  op,
    input  wire logic [smac_pkg::ADDR_W-1:0]           address,
    input  wire logic [smac_pkg::LEN_W-1:0]            length,
    input  wire logic [smac_pkg::SIDX_W-1:0]           shadow_index,
    input  wire logic [smac_pkg::FCNT_W-1:0]           fill_count,
    input  wire logic [smac_pkg::SHADOW_W-1:0]         fill_value,
    input  wire smac_pkg::pool_cfg_t                   pool,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [smac_pkg::STATUS_W-1:0]              status,
    output logic [smac_pkg::SHADOW_W-1:0]              bad_shadow,
    output logic                                       mem_we,
    output logic [$clog2(SHADOW_ENTRIES)-1:0]          mem_waddr,
    output logic [smac_pkg::SHADOW_W-1:0]              mem_wdata,
    output logic                                       mem_re,
    output logic [$clog2(SHADOW_ENTRIES)-1:0]          mem_raddr,
    input  wire logic [smac_pkg::SHADOW_W-1:0]         mem_rdata
);

    localparam int IW     = $clog2(SHADOW_ENTRIES);
    localparam int NW     = $clog2(SHADOW_ENTRIES + 1);
    localparam int CW     = ((NW > smac_pkg::FCNT_W) ? NW : smac_pkg::FCNT_W) + 1;
    localparam int GW     = smac_pkg::GIDX_W;
    // reciprocal of the entry count, underestimated: remainder lands below twice the count
    localparam int RECIP  = (1 << GW) / SHADOW_ENTRIES;
    localparam int RW_RAW = $clog2(RECIP + 1);
    localparam int RW     = (RW_RAW > 0) ? RW_RAW : 1;
    localparam int PW     = GW + RW;
    localparam int QNW    = RW + NW;
    localparam int DW     = ((GW > QNW) ? GW : QNW) + 1;
    localparam int KW     = smac_pkg::LEN_W + 1;

    localparam logic [RW-1:0] RECIP_V     = RW'(RECIP);
    localparam logic [IW-1:0] LAST_IDX    = IW'(SHADOW_ENTRIES - 1);
    localparam logic [NW-1:0] ENTRIES_NW  = NW'(SHADOW_ENTRIES);
    localparam logic [CW-1:0] ENTRIES_CW  = CW'(SHADOW_ENTRIES);
    localparam logic [DW-1:0] ENTRIES_DW  = DW'(SHADOW_ENTRIES);

    smac_pkg::state_t state_reg;
    smac_pkg::state_t state_next;

    // captured item
    logic [smac_pkg::ADDR_W-1:0]         addr_reg;
    logic [smac_pkg::ADDR_W-1:0]         addr_next;
    logic [smac_pkg::LEN_W-1:0]          len_reg;
    logic [smac_pkg::LEN_W-1:0]          len_next;
    logic [smac_pkg::SIDX_W-1:0]         sidx_reg;
    logic [smac_pkg::SIDX_W-1:0]         sidx_next;
    logic [smac_pkg::FCNT_W-1:0]         fcnt_reg;
    logic [smac_pkg::FCNT_W-1:0]         fcnt_next;
    logic [smac_pkg::SHADOW_W-1:0]       fval_reg;
    logic [smac_pkg::SHADOW_W-1:0]       fval_next;

    // range test and entry location
    logic [smac_pkg::TOP_W-1:0]          base_reg;
    logic [smac_pkg::TOP_W-1:0]          base_next;
    logic [smac_pkg::TOP_W-1:0]          room_reg;
    logic [smac_pkg::TOP_W-1:0]          room_next;
    logic                                above_reg;
    logic                                above_next;
    logic [GW-1:0]                       g0_reg;
    logic [GW-1:0]                       g0_next;
    logic [PW-1:0]                       prod_reg;
    logic [PW-1:0]                       prod_next;
    logic [QNW-1:0]                      qn_reg;
    logic [QNW-1:0]                      qn_next;
    logic [smac_pkg::GRAN_OFF_W-1:0]     last_off_reg;
    logic [smac_pkg::GRAN_OFF_W-1:0]     last_off_next;

    // scan and fill counters
    logic [IW-1:0]                       idx_reg;
    logic [IW-1:0]                       idx_next;
    logic [GW-1:0]                       issue_left_reg;
    logic [GW-1:0]                       issue_left_next;
    logic [GW-1:0]                       eval_left_reg;
    logic [GW-1:0]                       eval_left_next;
    logic                                pend_reg;
    logic                                pend_next;
    logic [smac_pkg::FCNT_W-1:0]         fill_left_reg;
    logic [smac_pkg::FCNT_W-1:0]         fill_left_next;

    // pending result and output register
    smac_pkg::status_t                   res_status_reg;
    smac_pkg::status_t                   res_status_next;
    logic [smac_pkg::SHADOW_W-1:0]       res_bad_reg;
    logic [smac_pkg::SHADOW_W-1:0]       res_bad_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    smac_pkg::status_t                   status_reg;
    smac_pkg::status_t                   status_next;
    logic [smac_pkg::SHADOW_W-1:0]       bad_reg;
    logic [smac_pkg::SHADOW_W-1:0]       bad_next;

    // combinational helpers
    logic [smac_pkg::TOP_W-1:0]          size_ext;
    logic [KW-1:0]                       ksum;
    logic                                in_pool;
    logic [RW-1:0]                       quot;
    logic [DW-1:0]                       diff;
    logic [IW-1:0]                       idx_inc;
    logic [smac_pkg::GRAN_OFF_W-1:0]     hi_off;
    logic                                gran_bad;
    logic [CW-1:0]                       start_ext;
    logic [CW-1:0]                       avail;

    always_comb
    begin
        size_ext  = smac_pkg::TOP_W'(pool.pool_size);
        // granules touched: ceil((offset + length) / 8)
        ksum      = KW'(len_reg) + KW'(addr_reg[smac_pkg::GRAN_OFF_W-1:0])
                    + KW'(smac_pkg::GRAN_LAST_OFF);
        in_pool   = (addr_reg >= base_reg) && !above_reg
                    && (smac_pkg::TOP_W'(len_reg) <= room_reg);
        quot      = prod_reg[PW-1:GW];
        diff      = DW'(g0_reg) - DW'(qn_reg);
        idx_inc   = (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
        hi_off    = (eval_left_reg == GW'(1)) ? last_off_reg : smac_pkg::GRAN_LAST_OFF;
        gran_bad  = (mem_rdata != '0)
                    && (mem_rdata[smac_pkg::SHADOW_W-1]
                        || (smac_pkg::SHADOW_W'(hi_off) >= mem_rdata));
        start_ext = CW'(sidx_reg);
        avail     = ENTRIES_CW - start_ext;
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        sidx_next       = sidx_reg;
        fcnt_next       = fcnt_reg;
        fval_next       = fval_reg;
        base_next       = base_reg;
        room_next       = room_reg;
        above_next      = above_reg;
        g0_next         = g0_reg;
        prod_next       = prod_reg;
        qn_next         = qn_reg;
        last_off_next   = last_off_reg;
        idx_next        = idx_reg;
        issue_left_next = issue_left_reg;
        eval_left_next  = eval_left_reg;
        pend_next       = 1'b0;
        fill_left_next  = fill_left_reg;
        res_status_next = res_status_reg;
        res_bad_next    = res_bad_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        bad_next        = bad_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = fval_reg;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;

        case (state_reg)
            smac_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                idx_next  = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = smac_pkg::ST_IDLE;
                end
            end

            smac_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next = address;
                    len_next  = length;
                    sidx_next = shadow_index;
                    fcnt_next = fill_count;
                    fval_next = fill_value;
                    state_next = (op == smac_pkg::OP_FILL) ? smac_pkg::ST_FILL_SETUP
                                                           : smac_pkg::ST_RANGE;
                end
            end

            smac_pkg::ST_RANGE:
            begin
                // pool start saturates at zero when the size exceeds the top
                base_next       = (size_ext > pool.pool_top) ? '0 : pool.pool_top - size_ext;
                room_next       = pool.pool_top - addr_reg;
                above_next      = addr_reg > pool.pool_top;
                issue_left_next = GW'(ksum >> smac_pkg::GRAN_SHIFT);
                eval_left_next  = GW'(ksum >> smac_pkg::GRAN_SHIFT);
                // adding seven is minus one in three bits: offset of the last byte
                last_off_next   = addr_reg[smac_pkg::GRAN_OFF_W-1:0]
                                  + len_reg[smac_pkg::GRAN_OFF_W-1:0]
                                  + smac_pkg::GRAN_LAST_OFF;
                state_next      = smac_pkg::ST_LOCATE;
            end

            smac_pkg::ST_LOCATE:
            begin
                res_bad_next = '0;
                if (!in_pool)
                begin
                    res_status_next = smac_pkg::STATUS_OUTSIDE;
                    state_next      = smac_pkg::ST_DONE;
                end
                else if (len_reg == '0)
                begin
                    res_status_next = smac_pkg::STATUS_OK;
                    state_next      = smac_pkg::ST_DONE;
                end
                else
                begin
                    g0_next    = GW'((addr_reg >> smac_pkg::GRAN_SHIFT)
                                     - (base_reg >> smac_pkg::GRAN_SHIFT));
                    state_next = smac_pkg::ST_MUL;
                end
            end

            smac_pkg::ST_MUL:
            begin
                prod_next  = PW'(g0_reg) * PW'(RECIP_V);
                state_next = smac_pkg::ST_SCALE;
            end

            smac_pkg::ST_SCALE:
            begin
                qn_next    = QNW'(quot) * QNW'(ENTRIES_NW);
                state_next = smac_pkg::ST_WRAP;
            end

            smac_pkg::ST_WRAP:
            begin
                if (diff >= ENTRIES_DW)
                begin
                    idx_next = IW'(diff - ENTRIES_DW);
                end
                else
                begin
                    idx_next = IW'(diff);
                end
                state_next = smac_pkg::ST_SCAN;
            end

            smac_pkg::ST_SCAN:
            begin
                // one read issued and one granule judged each cycle
                if (pend_reg && gran_bad)
                begin
                    res_status_next = smac_pkg::STATUS_VIOLATION;
                    res_bad_next    = mem_rdata;
                    state_next      = smac_pkg::ST_DONE;
                end
                else if (pend_reg && (eval_left_reg == GW'(1)))
                begin
                    res_status_next = smac_pkg::STATUS_OK;
                    res_bad_next    = '0;
                    state_next      = smac_pkg::ST_DONE;
                end
                else
                begin
                    if (pend_reg)
                    begin
                        eval_left_next = eval_left_reg - GW'(1);
                    end
                    if (issue_left_reg != '0)
                    begin
                        mem_re          = 1'b1;
                        idx_next        = idx_inc;
                        issue_left_next = issue_left_reg - GW'(1);
                        pend_next       = 1'b1;
                    end
                end
            end

            smac_pkg::ST_FILL_SETUP:
            begin
                res_status_next = smac_pkg::STATUS_OK;
                res_bad_next    = '0;
                if ((start_ext >= ENTRIES_CW) || (fcnt_reg == '0))
                begin
                    state_next = smac_pkg::ST_DONE;
                end
                else
                begin
                    fill_left_next = (CW'(fcnt_reg) < avail) ? fcnt_reg
                                                             : smac_pkg::FCNT_W'(avail);
                    idx_next       = IW'(start_ext);
                    state_next     = smac_pkg::ST_FILL;
                end
            end

            smac_pkg::ST_FILL:
            begin
                mem_we         = 1'b1;
                idx_next       = idx_inc;
                fill_left_next = fill_left_reg - smac_pkg::FCNT_W'(1);
                if (fill_left_reg == smac_pkg::FCNT_W'(1))
                begin
                    state_next = smac_pkg::ST_DONE;
                end
            end

            smac_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    bad_next       = res_bad_reg;
                    state_next     = smac_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = smac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smac_pkg::ST_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        sidx_reg       <= sidx_next;
        fcnt_reg       <= fcnt_next;
        fval_reg       <= fval_next;
        base_reg       <= base_next;
        room_reg       <= room_next;
        above_reg      <= above_next;
        g0_reg         <= g0_next;
        prod_reg       <= prod_next;
        qn_reg         <= qn_next;
        last_off_reg   <= last_off_next;
        issue_left_reg <= issue_left_next;
        eval_left_reg  <= eval_left_next;
        fill_left_reg  <= fill_left_next;
        res_status_reg <= res_status_next;
        res_bad_reg    <= res_bad_next;
        status_reg     <= status_next;
        bad_reg        <= bad_next;
    end

    assign in_stall   = (state_reg != smac_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign bad_shadow = bad_reg;

endmodule

`default_nettype wire

// File: rtl/core/shadow_memory_access_checker.sv
// check: range test, entry location, then a scan of the granules up to the first bad one
// outside-pool or zero-length check ends after the range test; fill of n entries: one write a cycle
// one item at a time; the next is taken once the result sits in the output register
// the entry index is found by a two-multiply reciprocal step ahead of the scan
// after reset all SHADOW_ENTRIES entries of the shadow store are zeroed one entry a cycle, input stalled
`default_nettype none

module shadow_memory_access_checker #(
    parameter int SHADOW_ENTRIES = 65536
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  op,
    input  wire logic [smac_pkg::ADDR_W-1:0]           address,
    input  wire logic [smac_pkg::LEN_W-1:0]            length,
    input  wire logic [smac_pkg::SIDX_W-1:0]           shadow_index,
    input  wire logic [smac_pkg::FCNT_W-1:0]           fill_count,
    input  wire logic [smac_pkg::SHADOW_W-1:0]         fill_value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [smac_pkg::STATUS_W-1:0]              status,
    output logic [smac_pkg::SHADOW_W-1:0]              bad_shadow,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [smac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [smac_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IW = $clog2(SHADOW_ENTRIES);

    smac_pkg::pool_cfg_t           pool;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [smac_pkg::SHADOW_W-1:0] mem_wdata;
    logic                          mem_re;
    logic [IW-1:0]                 mem_raddr;
    logic [smac_pkg::SHADOW_W-1:0] mem_rdata;

    smac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pool      (pool)
    );

    smac_engine #(
        .SHADOW_ENTRIES (SHADOW_ENTRIES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .address      (address),
        .length       (length),
        .shadow_index (shadow_index),
        .fill_count   (fill_count),
        .fill_value   (fill_value),
        .pool         (pool),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .bad_shadow   (bad_shadow),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    smac_ram #(
        .WIDTH (smac_pkg::SHADOW_W),
        .DEPTH (SHADOW_ENTRIES)
    ) u_shadow_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/smac_props.sv
// port-level assertions for the shadow memory access checker, bound to the top level
`default_nettype none

`include "shadow_memory_access_checker_defines.svh"

module smac_props (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_stall,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic [smac_pkg::STATUS_W-1:0]         status,
    input wire logic [smac_pkg::SHADOW_W-1:0]         bad_shadow
);

    // a stalled result beat holds
    `SMAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(bad_shadow), "stalled result changed")

    // one item in flight: an accepted beat closes the input
    `SMAC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall,
        in_stall, "input open right after an accepted beat")

    `SMAC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid,
        status == smac_pkg::STATUS_OK || status == smac_pkg::STATUS_OUTSIDE || status == smac_pkg::STATUS_VIOLATION,
        "unknown status code")

    `SMAC_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && status != smac_pkg::STATUS_VIOLATION,
        bad_shadow == '0, "shadow byte reported without a violation")

    // a violation always names a non-zero shadow byte
    `SMAC_ASSERT_NOW(a_bad_set, clk, rst_n, out_valid && status == smac_pkg::STATUS_VIOLATION,
        bad_shadow != '0, "violation with zero shadow byte")

endmodule

bind shadow_memory_access_checker smac_props u_smac_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .bad_shadow (bad_shadow)
);

`default_nettype wire
